// ===== sv/assert_macros.svh =====
// Assertion macros for the compositor RTL, used by tipc_unpremul.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, checked out of reset only.
`define TIPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent now, consequent in the cycle after.
`define TIPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tipc_pkg.sv =====
// Package for the tinted icon pixel compositor: types, register codes and
// shared arithmetic helpers. No dependencies.
package tipc_pkg;

  localparam int NumChan      = 3;
  localparam int DivStages    = 4;
  localparam int BitsPerStage = 2;

  typedef enum logic [1:0] {
    REG_TINT_COLOR    = 2'd0,
    REG_TINT_STRENGTH = 2'd1,
    REG_ICON_OPACITY  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [23:0] tint_color;
    logic [7:0]  tint_strength;
    logic [7:0]  icon_opacity;
  } cfg_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
  } pair_t;

  // Record carried through the un-premultiply divider.
  typedef struct packed {
    logic                         skip;
    logic [31:0]                  dst;
    logic [7:0]                   a;
    logic                         div_en;
    logic [NumChan-1:0][7:0]      col;
    logic [NumChan-1:0]           ovf;
    logic [NumChan-1:0][15:0]     rem;
    logic [NumChan-1:0][7:0]      quo;
  } div_t;

  typedef struct packed {
    logic                    skip;
    logic [31:0]             dst;
    logic [7:0]              a;
    logic [NumChan-1:0][7:0] col;
  } norm_t;

  typedef struct packed {
    logic                    skip;
    logic [31:0]             dst;
    logic [7:0]              fa;
    logic [NumChan-1:0][7:0] col;
  } tint_t;

  typedef struct packed {
    logic [31:0] blended;
    logic        we;
  } res_t;

  typedef struct packed {
    logic [15:0] rem;
    logic        qbit;
  } dstep_t;

  // Truncating x/255, exact for x up to 255*255.
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'h000, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // One restoring-division step against den shifted left by sh.
  function automatic dstep_t div_step(logic [15:0] rem, logic [7:0] den, logic [2:0] sh);
    logic [15:0] d;
    dstep_t      r;
    d = {8'h00, den} << sh;
    if (rem >= d) begin
      r.rem  = rem - d;
      r.qbit = 1'b1;
    end else begin
      r.rem  = rem;
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/tipc_if.sv =====
// Valid/ready channel interfaces for the compositor's pixel input and result.
// No dependencies.
interface tipc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_pixel;
  logic [31:0] dest_pixel;

  modport source (output valid, source_pixel, dest_pixel, input ready);
  modport sink   (input valid, source_pixel, dest_pixel, output ready);
endinterface

interface tipc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] blended_pixel;
  logic        write_enable;

  modport source (output valid, blended_pixel, write_enable, input ready);
  modport sink   (input valid, blended_pixel, write_enable, output ready);
endinterface

// ===== sv/tipc_unpremul.sv =====
// Source decode and pipelined un-premultiply divider (five stages).
// Depends on tipc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tipc_unpremul import tipc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  pair_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output norm_t out_data_o
);

  localparam int NSt = DivStages + 1;

  logic [NSt-1:0] vld_q;
  logic [NSt:0]   ld;
  div_t           s0_d, s0_q;
  div_t           dv_in [DivStages];
  div_t           dv_d [DivStages];
  div_t           dv_q [DivStages];
  div_t           dv_last;
  logic           last_vld, stalled, rem_ok, alpha_ok;

  assign ld[NSt] = out_ready_i;
  for (genvar k = 0; k < NSt; k++) begin : g_ld
    assign ld[k] = !vld_q[k] || ld[k+1];
  end
  assign in_ready_o = ld[0];

  // Feed each divider stage from the register before it.
  assign dv_in[0] = s0_q;
  for (genvar k = 1; k < DivStages; k++) begin : g_dv_in
    assign dv_in[k] = dv_q[k-1];
  end

  // Decode and build the rounded numerators c*255 + a/2.
  always_comb begin
    logic [7:0]  a;
    logic [15:0] n;
    a           = in_data_i.src[31:24];
    s0_d        = '0;
    s0_d.skip   = (in_data_i.src == 32'h0);
    s0_d.dst    = in_data_i.dst;
    s0_d.div_en = (a != 8'h00) && (a != 8'hFF);
    s0_d.a      = (a == 8'h00) ? 8'hFF : a;
    s0_d.col    = in_data_i.src[23:0];
    for (int ch = 0; ch < NumChan; ch++) begin
      n = {s0_d.col[ch], 8'h00} - {8'h00, s0_d.col[ch]} + {9'h000, a[7:1]};
      s0_d.rem[ch] = n;
      s0_d.ovf[ch] = (n >= {a, 8'h00});
    end
  end

  // Two quotient bits per stage, most significant first.
  always_comb begin
    dstep_t     ds;
    logic [2:0] sh;
    for (int j = 0; j < DivStages; j++) begin
      dv_d[j] = dv_in[j];
      for (int ch = 0; ch < NumChan; ch++) begin
        for (int b = 0; b < BitsPerStage; b++) begin
          sh = 3'(7 - BitsPerStage * j - b);
          ds = div_step(dv_d[j].rem[ch], dv_d[j].a, sh);
          dv_d[j].rem[ch]     = ds.rem;
          dv_d[j].quo[ch][sh] = ds.qbit;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSt; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      s0_q <= s0_d;
    end
    for (int j = 0; j < DivStages; j++) begin
      if (ld[j+1]) begin
        dv_q[j] <= dv_d[j];
      end
    end
  end

  // Clamp on overflow, pass colour through when no divide applies.
  always_comb begin
    out_data_o.skip = dv_q[DivStages-1].skip;
    out_data_o.dst  = dv_q[DivStages-1].dst;
    out_data_o.a    = dv_q[DivStages-1].a;
    for (int ch = 0; ch < NumChan; ch++) begin
      if (!dv_q[DivStages-1].div_en) begin
        out_data_o.col[ch] = dv_q[DivStages-1].col[ch];
      end else if (dv_q[DivStages-1].ovf[ch]) begin
        out_data_o.col[ch] = 8'hFF;
      end else begin
        out_data_o.col[ch] = dv_q[DivStages-1].quo[ch];
      end
    end
  end
  assign out_valid_o = vld_q[NSt-1];

  assign dv_last  = dv_q[DivStages-1];
  assign last_vld = vld_q[NSt-1];
  assign stalled  = last_vld && !out_ready_i;
  assign rem_ok   = !dv_last.div_en || dv_last.ovf[0] || (dv_last.rem[0] < 16'(dv_last.a));
  assign alpha_ok = !dv_last.div_en || (dv_last.a != 8'h00 && dv_last.a != 8'hFF);

  `TIPC_ASSERT(a_rem_below_den, !last_vld || rem_ok, "divider remainder not below alpha")
  `TIPC_ASSERT(a_div_alpha_partial, !last_vld || alpha_ok, "divide on full or zero alpha")
  `TIPC_ASSERT_NEXT(a_hold_stall, stalled, last_vld && $stable(dv_last), "stage moved on stall")

endmodule

// ===== sv/tipc_tint.sv =====
// Tint blend and opacity scaling (two stages).
// Depends on tipc_pkg.
module tipc_tint import tipc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  norm_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output tint_t out_data_o
);

  typedef struct packed {
    logic                     skip;
    logic [31:0]              dst;
    logic                     ten;
    logic [NumChan-1:0][7:0]  col;
    logic [NumChan-1:0][15:0] p1;
    logic [NumChan-1:0][15:0] p2;
    logic [15:0]              pa;
  } t1_t;

  logic                    vld1_q, vld2_q, ld1, ld2;
  t1_t                     t1_d, t1_q;
  tint_t                   t2_d, t2_q;
  logic [NumChan-1:0][7:0] tc;
  logic [7:0]              inv_s;

  assign ld2        = !vld2_q || out_ready_i;
  assign ld1        = !vld1_q || ld2;
  assign in_ready_o = ld1;
  assign tc         = cfg_i.tint_color;
  assign inv_s      = 8'hFF - cfg_i.tint_strength;

  // Form the weighted products.
  always_comb begin
    t1_d.skip = in_data_i.skip;
    t1_d.dst  = in_data_i.dst;
    t1_d.ten  = (cfg_i.tint_strength != 8'h00);
    t1_d.col  = in_data_i.col;
    t1_d.pa   = {8'h00, in_data_i.a} * {8'h00, cfg_i.icon_opacity};
    for (int ch = 0; ch < NumChan; ch++) begin
      t1_d.p1[ch] = {8'h00, in_data_i.col[ch]} * {8'h00, inv_s};
      t1_d.p2[ch] = {8'h00, tc[ch]} * {8'h00, cfg_i.tint_strength};
    end
  end

  // Sum and divide; drop a source whose scaled alpha comes out zero.
  always_comb begin
    t2_d.dst  = t1_q.dst;
    t2_d.fa   = div255(t1_q.pa);
    t2_d.skip = t1_q.skip || (t2_d.fa == 8'h00);
    for (int ch = 0; ch < NumChan; ch++) begin
      t2_d.col[ch] = t1_q.ten ? div255(t1_q.p1[ch] + t1_q.p2[ch]) : t1_q.col[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      if (ld1) begin
        vld1_q <= in_valid_i;
      end
      if (ld2) begin
        vld2_q <= vld1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      t1_q <= t1_d;
    end
    if (ld2) begin
      t2_q <= t2_d;
    end
  end

  assign out_valid_o = vld2_q;
  assign out_data_o  = t2_q;

endmodule

// ===== sv/tipc_over.sv =====
// Premultiply and source-over composite onto the destination (two stages).
// Depends on tipc_pkg.
module tipc_over import tipc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  tint_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_data_o
);

  typedef struct packed {
    logic                     skip;
    logic [31:0]              dst;
    logic [7:0]               fa;
    logic [NumChan-1:0][15:0] pc;
    logic [3:0][15:0]         pd;
  } t3_t;

  logic             vld3_q, vld4_q, ld3, ld4;
  t3_t              t3_d, t3_q;
  res_t             t4_d, t4_q;
  logic [7:0]       inv_a;
  logic [3:0][7:0]  dch;

  assign ld4        = !vld4_q || out_ready_i;
  assign ld3        = !vld3_q || ld4;
  assign in_ready_o = ld3;
  assign inv_a      = 8'hFF - in_data_i.fa;
  assign dch        = in_data_i.dst;

  always_comb begin
    t3_d.skip = in_data_i.skip;
    t3_d.dst  = in_data_i.dst;
    t3_d.fa   = in_data_i.fa;
    for (int ch = 0; ch < NumChan; ch++) begin
      t3_d.pc[ch] = {8'h00, in_data_i.col[ch]} * {8'h00, in_data_i.fa};
    end
    for (int ch = 0; ch < 4; ch++) begin
      t3_d.pd[ch] = {8'h00, dch[ch]} * {8'h00, inv_a};
    end
  end

  // Keep the low byte of each channel sum; pass the destination on a skip.
  always_comb begin
    logic [3:0][7:0] px;
    px[3] = t3_q.fa + div255(t3_q.pd[3]);
    for (int ch = 0; ch < NumChan; ch++) begin
      px[ch] = div255(t3_q.pc[ch]) + div255(t3_q.pd[ch]);
    end
    t4_d.we      = !t3_q.skip;
    t4_d.blended = t3_q.skip ? t3_q.dst : px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (ld3) begin
        vld3_q <= in_valid_i;
      end
      if (ld4) begin
        vld4_q <= vld3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      t3_q <= t3_d;
    end
    if (ld4) begin
      t4_q <= t4_d;
    end
  end

  assign out_valid_o = vld4_q;
  assign out_data_o  = t4_q;

endmodule

// ===== sv/tinted_icon_pixel_composite.sv =====
// Top level of the tinted icon pixel compositor: configuration registers and
// the three pipeline segments. Depends on tipc_pkg, tipc_if, tipc_unpremul,
// tipc_tint and tipc_over.
//
//   channel   direction  handshake      payload
//   pix_in    sink       valid/ready    source_pixel[31:0], dest_pixel[31:0]
//   pix_out   source     valid/ready    blended_pixel[31:0], write_enable
//   cfg       write      cfg_we_i       cfg_idx_i[1:0], cfg_data_i[23:0]
//
// One transaction is taken per cycle while pix_out is not stalled. Nine
// register stages: decode, four divider stages (two quotient bits each), tint
// products, tint/opacity divide, composite products, composite sum.
// Reset clears valid bits and loads the register reset values.
// Each stage advances when empty or when the stage after it advances, so a
// stall at pix_out fills bubbles first and then holds every stage in place.
module tinted_icon_pixel_composite import tipc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [23:0]      cfg_data_i,
  tipc_in_if.sink          pix_in,
  tipc_out_if.source       pix_out
);

  cfg_t  cfg_q;
  pair_t in_pair;
  norm_t norm;
  tint_t tinted;
  res_t  res;
  logic  norm_vld, norm_rdy, tint_vld, tint_rdy;

  // Register writes; an unused index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tint_color    <= 24'h000000;
      cfg_q.tint_strength <= 8'h00;
      cfg_q.icon_opacity  <= 8'hFF;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TINT_COLOR:    cfg_q.tint_color    <= cfg_data_i;
        REG_TINT_STRENGTH: cfg_q.tint_strength <= cfg_data_i[7:0];
        REG_ICON_OPACITY:  cfg_q.icon_opacity  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_pair.src = pix_in.source_pixel;
  assign in_pair.dst = pix_in.dest_pixel;

  // Normalise alpha and un-premultiply the colour.
  tipc_unpremul u_unpremul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_in.valid),
    .in_ready_o  (pix_in.ready),
    .in_data_i   (in_pair),
    .out_valid_o (norm_vld),
    .out_ready_i (norm_rdy),
    .out_data_o  (norm)
  );

  // Blend toward the tint colour and scale alpha by the opacity.
  tipc_tint u_tint (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (norm_vld),
    .in_ready_o  (norm_rdy),
    .in_data_i   (norm),
    .out_valid_o (tint_vld),
    .out_ready_i (tint_rdy),
    .out_data_o  (tinted)
  );

  // Premultiply and composite; the last stage is the output register.
  tipc_over u_over (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tint_vld),
    .in_ready_o  (tint_rdy),
    .in_data_i   (tinted),
    .out_valid_o (pix_out.valid),
    .out_ready_i (pix_out.ready),
    .out_data_o  (res)
  );

  assign pix_out.blended_pixel = res.blended;
  assign pix_out.write_enable  = res.we;

endmodule

// ===== test/tipc_blend_checker.sv =====
// Checker for the tinted icon pixel compositor: tracks register writes, predicts each
// composited pixel and compares it with the pixel output. Depends on tipc_pkg and tipc_if.
module tipc_blend_checker import tipc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  tipc_in_if          pix_in,
  tipc_out_if         pix_out,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t blend_cfg;
  res_t expected_pixels[$];

  function automatic int unsigned unpremultiply(int unsigned c, int unsigned a);
    int unsigned u;
    u = (c * 255 + a / 2) / a;
    return (u > 255) ? 255 : u;
  endfunction

  function automatic int unsigned tint_channel(int unsigned c, int unsigned t,
                                               int unsigned s);
    return (c * (255 - s) + t * s) / 255;
  endfunction

  function automatic logic [7:0] over_channel(int unsigned pm, int unsigned d,
                                              int unsigned inv);
    int unsigned sum;
    sum = pm + (d * inv) / 255;
    return sum[7:0];
  endfunction

  function automatic res_t blend_pixel(logic [31:0] src, logic [31:0] dst, cfg_t cfg);
    int unsigned a, r, g, b, fa, inv;
    res_t        res;
    a = src[31:24];
    r = src[23:16];
    g = src[15:8];
    b = src[7:0];
    res.blended = dst;
    res.we      = 1'b0;
    if (src == 32'h0) return res;
    if (a == 0) begin
      a = 255;
    end else if (a < 255) begin
      r = unpremultiply(r, a);
      g = unpremultiply(g, a);
      b = unpremultiply(b, a);
    end
    if (cfg.tint_strength != 8'h00) begin
      r = tint_channel(r, cfg.tint_color[23:16], cfg.tint_strength);
      g = tint_channel(g, cfg.tint_color[15:8], cfg.tint_strength);
      b = tint_channel(b, cfg.tint_color[7:0], cfg.tint_strength);
    end
    fa = (a * cfg.icon_opacity) / 255;
    if (fa == 0) return res;
    inv = 255 - fa;
    res.blended = {over_channel(fa, dst[31:24], inv),
                   over_channel((r * fa) / 255, dst[23:16], inv),
                   over_channel((g * fa) / 255, dst[15:8], inv),
                   over_channel((b * fa) / 255, dst[7:0], inv)};
    res.we = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t        want;
    int unsigned errs;
    if (!rst_ni) begin
      blend_cfg.tint_color    <= 24'h0;
      blend_cfg.tint_strength <= 8'h00;
      blend_cfg.icon_opacity  <= 8'hFF;
      expected_pixels.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_TINT_COLOR:    blend_cfg.tint_color    <= cfg_data_i;
          REG_TINT_STRENGTH: blend_cfg.tint_strength <= cfg_data_i[7:0];
          REG_ICON_OPACITY:  blend_cfg.icon_opacity  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (pix_out.valid && pix_out.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none actual %08h we %0b", $time,
                   pix_out.blended_pixel, pix_out.write_enable);
          errs++;
        end else begin
          want = expected_pixels.pop_front();
          if (pix_out.blended_pixel !== want.blended) begin
            $display("%0t: blended_pixel expected %08h actual %08h", $time,
                     want.blended, pix_out.blended_pixel);
            errs++;
          end
          if (pix_out.write_enable !== want.we) begin
            $display("%0t: write_enable expected %0b actual %0b", $time,
                     want.we, pix_out.write_enable);
            errs++;
          end
        end
      end
      if (pix_in.valid && pix_in.ready)
        expected_pixels.push_back(blend_pixel(pix_in.source_pixel, pix_in.dest_pixel,
                                              blend_cfg));
      mismatch_count_o <= mismatch_count_o + errs;
      pending_o        <= expected_pixels.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the compositor testbench: clock, reset, pixel and register stimulus, verdict.
// Depends on tipc_pkg, tipc_if, tinted_icon_pixel_composite and tipc_blend_checker.
module tb_top import tipc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transaction or register write before the run is abandoned.
  localparam int unsigned StallLimit    = 400;
  localparam int unsigned PhaseCount    = 7;
  localparam int unsigned PhaseItems    = 60;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned DirectedCount = 17;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [23:0] cfg_data;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned quiet_cycles;
  bit          idling_on;

  tipc_in_if  pix_in_bus ();
  tipc_out_if pix_out_bus ();

  tinted_icon_pixel_composite i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_in     (pix_in_bus),
    .pix_out    (pix_out_bus)
  );

  tipc_blend_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .pix_in           (pix_in_bus),
    .pix_out          (pix_out_bus),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: any transaction on either channel, or a register write, counts as progress.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((pix_in_bus.valid && pix_in_bus.ready) || (pix_out_bus.valid && pix_out_bus.ready) ||
        cfg_we || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result back-pressure: ready high for a random run, then low for a burst if idling_on.
  initial begin
    pix_out_bus.ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (idling_on) begin
        pix_out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        pix_out_bus.ready <= 1'b1;
      end
    end
  end

  // Present one pixel pair (after a random idle gap when idling_on) and hold it until the
  // transaction completes. Valid then stays high so back-to-back pairs go at full rate.
  task automatic push_pixel(input logic [31:0] src, input logic [31:0] dst);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      pix_in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    pix_in_bus.valid        <= 1'b1;
    pix_in_bus.source_pixel <= src;
    pix_in_bus.dest_pixel   <= dst;
    @(posedge clk_i);
    while (!pix_in_bus.ready) @(posedge clk_i);
  endtask

  // Stop sending and wait for every predicted pixel to come out. Every pair produces a
  // result, so an empty expectation store means the pipeline is empty.
  task automatic wait_idle();
    pix_in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [23:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Half well-formed premultiplied pixels, half skipped, opaque, zero-alpha and raw ones.
  function automatic logic [31:0] random_source();
    logic [31:0] raw;
    logic [7:0]  a;
    raw = $urandom();
    a   = 8'($urandom_range(1, 254));
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return {8'h00, raw[23:0]};
      2:       return {8'hFF, raw[23:0]};
      3, 4:    return raw;
      default: return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                       8'($urandom_range(0, a))};
    endcase
  endfunction

  function automatic logic [7:0] random_byte(input logic [7:0] lo_pick,
                                             input logic [7:0] hi_pick);
    case ($urandom_range(0, 3))
      0:       return lo_pick;
      1:       return hi_pick;
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    logic [31:0] directed_src[DirectedCount];
    logic [31:0] directed_dst[DirectedCount];
    logic [23:0] colour;
    logic [7:0]  strength;
    logic [7:0]  opacity;

    idling_on = 1'b1;
    rst_ni                  <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= REG_TINT_COLOR;
    cfg_data                <= 24'h0;
    pix_in_bus.valid        <= 1'b0;
    pix_in_bus.source_pixel <= 32'h0;
    pix_in_bus.dest_pixel   <= 32'h0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs under the reset register values: skipped source, zero alpha with
    // colour, opaque, alpha at one and just below full, un-premultiply clamping, and
    // destinations that are not premultiplied.
    directed_src = '{32'h0000_0000, 32'h0000_0000, 32'h00FF_8040, 32'h0000_0001,
                     32'hFFFF_FFFF, 32'hFF00_0000, 32'h0101_0101, 32'h01FF_FFFF,
                     32'hFEFE_FEFE, 32'hFEFF_FFFF, 32'h80FF_0080, 32'h8080_8080,
                     32'h8000_0000, 32'h7F3F_1F0F, 32'h4010_2030, 32'h0201_0001,
                     32'hFF12_3456};
    directed_dst = '{32'h1234_5678, 32'h0000_0000, 32'h8040_2010, 32'hFFFF_FFFF,
                     32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                     32'h7F7F_7F7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h1234_5678, 32'h00FF_00FF, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                     32'h5555_5555};
    foreach (directed_src[i]) push_pixel(directed_src[i], directed_dst[i]);

    // Random phases, each under its own register setting. The first three pin the
    // extremes: full tint to white, the weakest tint with near-full opacity (alpha of
    // one then scales to zero and is skipped), and zero opacity where every pixel skips.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          colour = 24'hFF_FFFF; strength = 8'hFF; opacity = 8'hFF;
        end
        1: begin
          colour = 24'h00_0000; strength = 8'h01; opacity = 8'hFE;
        end
        2: begin
          colour = 24'($urandom()); strength = 8'($urandom()); opacity = 8'h00;
        end
        default: begin
          colour   = {random_byte(8'h00, 8'hFF), random_byte(8'h00, 8'hFF),
                      random_byte(8'h00, 8'hFF)};
          strength = random_byte(8'h00, 8'hFF);
          opacity  = random_byte(8'h01, 8'hFF);
        end
      endcase
      // Run the last phase flat out on both sides.
      idling_on = (phase != PhaseCount - 1);
      wait_idle();
      write_reg(REG_TINT_COLOR, colour);
      write_reg(REG_TINT_STRENGTH, {16'h0, strength});
      write_reg(REG_ICON_OPACITY, {16'h0, opacity});
      repeat (PhaseItems) push_pixel(random_source(), $urandom());
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
